// ===== rtl/console_line_edit_buffer_macros.svh =====
// ------------------------------------------------------------------------
// Console line edit buffer assertion macros
// Shared assertion forms for the line edit buffer; clocked on clk, quiet in reset.
// ------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDIT_BUFFER_MACROS_SVH
`define CONSOLE_LINE_EDIT_BUFFER_MACROS_SVH

// Same-cycle implication.
`define CLB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CLB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/clb_pkg.sv =====
// ------------------------------------------------------------------------
// Console line edit buffer package
// Ring geometry, key codes, result codes and the command passed front to back.
// ------------------------------------------------------------------------
package clb_pkg;

	localparam int RING_DEPTH = 128;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int IDX_W      = SLOT_W + 1;

	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	localparam logic [7:0] KEY_NUL    = 8'h00;
	localparam logic [7:0] KEY_CTRL_D = 8'h04;
	localparam logic [7:0] KEY_CTRL_H = 8'h08;
	localparam logic [7:0] KEY_NL     = 8'h0A;
	localparam logic [7:0] KEY_CR     = 8'h0D;
	localparam logic [7:0] KEY_CTRL_P = 8'h10;
	localparam logic [7:0] KEY_CTRL_U = 8'h15;
	localparam logic [7:0] KEY_CTRL_Z = 8'h1A;
	localparam logic [7:0] KEY_DEL    = 8'h7F;

	localparam logic [7:0] DEFAULT_ATTR = 8'h07;

	localparam logic [1:0] ECHO_NONE  = 2'd0;
	localparam logic [1:0] ECHO_PRINT = 2'd1;
	localparam logic [1:0] ECHO_ERASE = 2'd2;

	localparam logic [2:0] READ_NONE    = 3'd0;
	localparam logic [2:0] READ_DATA    = 3'd1;
	localparam logic [2:0] READ_NEWLINE = 3'd2;
	localparam logic [2:0] READ_EOF     = 3'd3;
	localparam logic [2:0] READ_EMPTY   = 3'd4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_KILL,
		OP_ERASE,
		OP_STORE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic       mid;
	} cmd_t;

	typedef struct packed {
		logic [1:0] echo_kind;
		logic [7:0] echo_char;
		logic [7:0] echo_attr;
		logic [7:0] erase_count;
		logic [2:0] read_kind;
		logic [7:0] read_byte;
	} res_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} bk_state_t;

endpackage

// ===== rtl/clb_front.sv =====
// ------------------------------------------------------------------------
// Console line edit buffer front end
// Decodes an incoming item into one back-end command.
// ------------------------------------------------------------------------
module clb_front (
	input  logic          func,
	input  logic [7:0]    key_code,
	input  logic          mid_read,
	output clb_pkg::cmd_t cmd
);

	always_comb begin
		cmd.ch  = key_code;
		cmd.mid = mid_read;
		cmd.op  = clb_pkg::OP_NOP;
		if (func) begin
			cmd.op = clb_pkg::OP_READ;
		end else begin
			unique case (key_code)
				clb_pkg::KEY_NUL, clb_pkg::KEY_CTRL_Z, clb_pkg::KEY_CTRL_P: begin
					cmd.op = clb_pkg::OP_NOP;
				end
				clb_pkg::KEY_CTRL_U: begin
					cmd.op = clb_pkg::OP_KILL;
				end
				clb_pkg::KEY_CTRL_H, clb_pkg::KEY_DEL: begin
					cmd.op = clb_pkg::OP_ERASE;
				end
				clb_pkg::KEY_CR: begin
					// store carriage return as newline
					cmd.op = clb_pkg::OP_STORE;
					cmd.ch = clb_pkg::KEY_NL;
				end
				default: begin
					cmd.op = clb_pkg::OP_STORE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/clb_cmd_fifo.sv =====
// ------------------------------------------------------------------------
// Console line edit buffer command queue
// Short queue of decoded commands between front and back end.
// ------------------------------------------------------------------------
module clb_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  clb_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output clb_pkg::cmd_t rd_cmd,
	output logic          avail
);

	clb_pkg::cmd_t                  entry_q [clb_pkg::CQ_DEPTH];
	logic [clb_pkg::CQ_PTR_W-1:0]   wr_ptr_q;
	logic [clb_pkg::CQ_PTR_W-1:0]   rd_ptr_q;
	logic [clb_pkg::CQ_CNT_W-1:0]   count_q;
	logic                           do_wr;
	logic                           do_rd;

	assign full   = (count_q == clb_pkg::CQ_CNT_W'(clb_pkg::CQ_DEPTH));
	assign avail  = (count_q != '0);
	assign rd_cmd = entry_q[rd_ptr_q];
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && avail;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/clb_back.sv =====
// ------------------------------------------------------------------------
// Console line edit buffer back end
// Owns the ring and its indices, carries out commands, holds the result.
// ------------------------------------------------------------------------
`include "console_line_edit_buffer_macros.svh"

module clb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    echo_color,
	input  logic          cmd_avail,
	input  clb_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          res_valid,
	output clb_pkg::res_t res,
	input  logic          res_pop
);

	logic [7:0]                  ring_mem [clb_pkg::RING_DEPTH];
	logic [7:0]                  rd_data_q;
	logic [clb_pkg::IDX_W-1:0]   read_idx_q;
	logic [clb_pkg::IDX_W-1:0]   commit_idx_q;
	logic [clb_pkg::IDX_W-1:0]   edit_idx_q;
	logic                        mid_q;
	logic                        res_valid_q;
	clb_pkg::res_t               res_q;
	clb_pkg::bk_state_t          state_q;
	clb_pkg::bk_state_t          state_d;

	logic                        slot_free;
	logic                        mem_we;
	logic                        mem_re;
	logic [clb_pkg::SLOT_W-1:0]  mem_waddr;
	logic [7:0]                  mem_wdata;
	logic [clb_pkg::IDX_W-1:0]   read_idx_d;
	logic [clb_pkg::IDX_W-1:0]   commit_idx_d;
	logic [clb_pkg::IDX_W-1:0]   edit_idx_d;
	logic                        res_load;
	clb_pkg::res_t               res_d;
	logic [clb_pkg::IDX_W-1:0]   edit_span;
	logic [clb_pkg::IDX_W-1:0]   commit_span;
	logic [clb_pkg::IDX_W-1:0]   kill_n;
	logic [clb_pkg::IDX_W-1:0]   edit_inc;
	logic                        ring_has_data;

	assign slot_free     = !res_valid_q || res_pop;
	assign edit_span     = edit_idx_q - read_idx_q;
	assign commit_span   = commit_idx_q - read_idx_q;
	assign kill_n        = edit_idx_q - commit_idx_q;
	assign edit_inc      = edit_idx_q + 1'b1;
	assign ring_has_data = (read_idx_q != commit_idx_q);
	assign res_valid     = res_valid_q;
	assign res           = res_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clb_pkg::BK_IDLE: begin
				if (cmd_avail && slot_free && cmd.op == clb_pkg::OP_READ && ring_has_data) begin
					state_d = clb_pkg::BK_READ;
				end
			end
			clb_pkg::BK_READ: begin
				if (slot_free) begin
					state_d = clb_pkg::BK_IDLE;
				end
			end
			default: state_d = clb_pkg::BK_IDLE;
		endcase
	end

	// datapath controls and result
	always_comb begin
		cmd_take     = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_waddr    = edit_idx_q[clb_pkg::SLOT_W-1:0];
		mem_wdata    = cmd.ch;
		read_idx_d   = read_idx_q;
		commit_idx_d = commit_idx_q;
		edit_idx_d   = edit_idx_q;
		res_load     = 1'b0;
		res_d        = '0;
		unique case (state_q)
			clb_pkg::BK_IDLE: begin
				if (cmd_avail && slot_free) begin
					cmd_take = 1'b1;
					res_load = 1'b1;
					unique case (cmd.op)
						clb_pkg::OP_NOP: begin
							res_d = '0;
						end
						clb_pkg::OP_KILL: begin
							if (kill_n != '0) begin
								edit_idx_d        = commit_idx_q;
								res_d.echo_kind   = clb_pkg::ECHO_ERASE;
								res_d.echo_attr   = clb_pkg::DEFAULT_ATTR;
								res_d.erase_count = (32'(kill_n) > 32'd255) ? 8'd255 : 8'(kill_n);
							end
						end
						clb_pkg::OP_ERASE: begin
							if (kill_n != '0) begin
								edit_idx_d        = edit_idx_q - 1'b1;
								res_d.echo_kind   = clb_pkg::ECHO_ERASE;
								res_d.echo_attr   = clb_pkg::DEFAULT_ATTR;
								res_d.erase_count = 8'd1;
							end
						end
						clb_pkg::OP_STORE: begin
							// drop the byte when the ring is already full
							if (!edit_span[clb_pkg::IDX_W-1]) begin
								mem_we          = 1'b1;
								edit_idx_d      = edit_inc;
								res_d.echo_kind = clb_pkg::ECHO_PRINT;
								res_d.echo_char = cmd.ch;
								res_d.echo_attr = (echo_color != 8'd0) ? echo_color
									: clb_pkg::DEFAULT_ATTR;
								if (cmd.ch == clb_pkg::KEY_NL || cmd.ch == clb_pkg::KEY_CTRL_D ||
									(edit_inc - read_idx_q) ==
									clb_pkg::IDX_W'(clb_pkg::RING_DEPTH)) begin
									commit_idx_d = edit_inc;
								end
							end
						end
						clb_pkg::OP_READ: begin
							if (ring_has_data) begin
								// fetch the byte; finish next cycle
								mem_re   = 1'b1;
								res_load = 1'b0;
							end else begin
								res_d.read_kind = clb_pkg::READ_EMPTY;
							end
						end
						default: begin
							res_d = '0;
						end
					endcase
				end
			end
			clb_pkg::BK_READ: begin
				if (slot_free) begin
					res_load = 1'b1;
					if (rd_data_q == clb_pkg::KEY_CTRL_D) begin
						// leave end of file queued when the read already has bytes
						if (!mid_q) begin
							read_idx_d = read_idx_q + 1'b1;
						end
						res_d.read_kind = clb_pkg::READ_EOF;
					end else begin
						read_idx_d      = read_idx_q + 1'b1;
						res_d.read_kind = (rd_data_q == clb_pkg::KEY_NL) ? clb_pkg::READ_NEWLINE
							: clb_pkg::READ_DATA;
						res_d.read_byte = rd_data_q;
					end
				end
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// ring memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= ring_mem[read_idx_q[clb_pkg::SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			mid_q <= cmd.mid;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= clb_pkg::BK_IDLE;
			read_idx_q   <= '0;
			commit_idx_q <= '0;
			edit_idx_q   <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			read_idx_q   <= read_idx_d;
			commit_idx_q <= commit_idx_d;
			edit_idx_q   <= edit_idx_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`CLB_ASSERT_NOW(a_commit_within_edit, 1'b1, commit_span <= edit_span, "commit index passed edit index")
	`CLB_ASSERT_NOW(a_ring_not_overfilled, 1'b1, edit_span <= clb_pkg::IDX_W'(clb_pkg::RING_DEPTH), "ring holds more than its depth")
	`CLB_ASSERT_NOW(a_read_has_data, state_q == clb_pkg::BK_READ, ring_has_data, "read pending with no committed byte")
	`CLB_ASSERT_NOW(a_no_write_in_read, state_q == clb_pkg::BK_READ, !mem_we && !cmd_take, "ring written or command taken during read")
	`CLB_ASSERT_NEXT(a_fetch_finishes, mem_re, state_q == clb_pkg::BK_READ, "ring fetch without read completion state")

endmodule

// ===== rtl/console_line_edit_buffer.sv =====
// ------------------------------------------------------------------------
// Console line edit buffer
// Console input ring with line editing: keystrokes in, echo and read bytes out.
// ------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------
//  input     push / full            func, key_code, mid_read
//  result    empty / pop            echo_kind, echo_char, echo_attr,
//                                   erase_count, read_kind, read_byte
//  config    cfg_valid / cfg_ready  cfg_data (echo attribute, 0 means 7)
//
//  A keystroke is carried out in the idle state; a read that finds committed data
//  also passes through the read state, set by the registered read port of the ring memory.
//  An accepted item passes through the command queue into the result register, a read
//  that finds committed data through the ring's read register and the read state as well.
//  A two-entry command queue parts front from back, so pushes continue while a result waits.
//  Reset clears indices and control; the ring is not cleared, as reads reach only written bytes.
//  The config port is always ready.
//
module console_line_edit_buffer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       func,
	input  logic [7:0] key_code,
	input  logic       mid_read,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] echo_kind,
	output logic [7:0] echo_char,
	output logic [7:0] echo_attr,
	output logic [7:0] erase_count,
	output logic [2:0] read_kind,
	output logic [7:0] read_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	clb_pkg::cmd_t front_cmd;
	clb_pkg::cmd_t queue_cmd;
	clb_pkg::res_t res;
	logic          queue_avail;
	logic          queue_take;
	logic          res_valid;
	logic          res_pop;
	logic [7:0]    echo_color_q;

	// Config: one register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_color_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			echo_color_q <= cfg_data;
		end
	end

	// Front: decode the item
	clb_front u_front (
		.func     (func),
		.key_code (key_code),
		.mid_read (mid_read),
		.cmd      (front_cmd)
	);

	// Queue: hold decoded commands until the back end is free
	clb_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_cmd (front_cmd),
		.full   (full),
		.rd_en  (queue_take),
		.rd_cmd (queue_cmd),
		.avail  (queue_avail)
	);

	// Back: update ring and indices, present one result at a time
	assign res_pop = pop && res_valid;

	clb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.echo_color (echo_color_q),
		.cmd_avail  (queue_avail),
		.cmd        (queue_cmd),
		.cmd_take   (queue_take),
		.res_valid  (res_valid),
		.res        (res),
		.res_pop    (res_pop)
	);

	assign empty       = !res_valid;
	assign echo_kind   = res.echo_kind;
	assign echo_char   = res.echo_char;
	assign echo_attr   = res.echo_attr;
	assign erase_count = res.erase_count;
	assign read_kind   = res.read_kind;
	assign read_byte   = res.read_byte;

endmodule
